// ----- src/rtwp_pkg.sv -----
package rtwp_pkg;

	localparam int TRIG_FRACTION_BITS = 15;
	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN = 24;
	localparam int HALF_TURN = 23040;
	localparam int QUARTER_TURN = 11520;
	localparam int FULL_TURN = 46080;
	localparam longint GAIN_Q30 = 64'd652032874;
	localparam int ZW = 34;

	localparam logic [15:0] RESET_RANGE_LIMIT = 16'd4800;
	localparam logic [15:0] RESET_RANGE_MINIMUM = 16'd80;
	localparam logic [15:0] RESET_WIDTH = 16'hffff;

	typedef enum logic [2:0] {
		REG_RANGE_LIMIT = 3'd0,
		REG_RANGE_MINIMUM = 3'd1,
		REG_WIDTH_X = 3'd2,
		REG_WIDTH_Y = 3'd3,
		REG_WIDTH_Z = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [15:0] distance;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] start_z;
	} in_beat_t;

	typedef struct packed {
		logic valid_res;
		logic [15:0] point_x;
		logic [15:0] point_y;
		logic [15:0] point_z;
	} out_beat_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd188743680;
			1: r = 34'sd111421900;
			2: r = 34'sd58872272;
			3: r = 34'sd29884485;
			4: r = 34'sd15000234;
			5: r = 34'sd7507429;
			6: r = 34'sd3754631;
			7: r = 34'sd1877430;
			8: r = 34'sd938729;
			9: r = 34'sd469366;
			10: r = 34'sd234683;
			11: r = 34'sd117342;
			12: r = 34'sd58671;
			13: r = 34'sd29335;
			14: r = 34'sd14668;
			15: r = 34'sd7334;
			16: r = 34'sd3667;
			17: r = 34'sd1833;
			18: r = 34'sd917;
			19: r = 34'sd458;
			20: r = 34'sd229;
			21: r = 34'sd115;
			22: r = 34'sd57;
			23: r = 34'sd29;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/rtwp_cordic.sv -----
module rtwp_cordic #(
	parameter int FRAC = rtwp_pkg::TRIG_FRACTION_BITS,
	parameter int STEPS = rtwp_pkg::CORDIC_STEPS,
	parameter int SIDE = 1
) (
	input logic clk,
	input logic en,
	input logic signed [16:0] angle,
	input logic [SIDE-1:0] side_in,
	output logic [SIDE-1:0] side_out,
	output logic signed [FRAC+2:0] sin_val,
	output logic signed [FRAC+2:0] cos_val
);
	import rtwp_pkg::*;

	localparam int N = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
	localparam int XW = FRAC + 3;
	localparam logic signed [XW-1:0] X0 =
		XW'((GAIN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));

	logic signed [XW-1:0] x_s [N+1];
	logic signed [XW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic flip_s [N+1];
	logic [SIDE-1:0] side_s [N+1];

	logic signed [17:0] a0, a1;
	logic flip0;

	always_comb begin
		a0 = 18'(angle);
		if (a0 > 18'sd23040) a0 = a0 - 18'sd46080;
		if (a0 < -18'sd23040) a0 = a0 + 18'sd46080;
		a1 = a0;
		flip0 = 1'b0;
		if (a0 > 18'sd11520) begin
			a1 = a0 - 18'sd23040;
			flip0 = 1'b1;
		end else if (a0 < -18'sd11520) begin
			a1 = a0 + 18'sd23040;
			flip0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= X0;
			y_s[0] <= '0;
			z_s[0] <= ZW'(a1) <<< 15;
			flip_s[0] <= flip0;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_entry(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_entry(i);
				end
				flip_s[i+1] <= flip_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign sin_val = flip_s[N] ? -y_s[N] : y_s[N];
	assign cos_val = flip_s[N] ? -x_s[N] : x_s[N];
	assign side_out = side_s[N];
endmodule

// ----- src/range_to_world_point_unit.sv -----
// Range-to-world point projection. Fully pipelined: one beat accepted per cycle
// while the pipe advances, passing these stages (one input stage, one CORDIC load stage plus
// one stage per iteration producing all six sines and cosines in parallel, three
// rotation stages of registered products and sums, and the output register that
// also takes the clamp).
// Each beat gives exactly one result; out-of-window distances or modes 6 and 7
// give valid_res 0 with zero coordinates. The whole pipe advances when the
// output register is empty or being taken.
module range_to_world_point_unit #(
	parameter int TRIG_FRACTION_BITS = rtwp_pkg::TRIG_FRACTION_BITS,
	parameter int CORDIC_STEPS = rtwp_pkg::CORDIC_STEPS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rtwp_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rtwp_pkg::out_beat_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	import rtwp_pkg::*;

	localparam int F = TRIG_FRACTION_BITS;
	localparam int TW = F + 3;
	localparam int N = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int CL = N + 1;
	localparam int VW = 20;
	localparam int PW = VW + TW;
	localparam int SW = PW + 2;
	localparam int SIDE = 1 + 3 + 17 + 48;

	logic [15:0] range_limit_q, range_minimum_q;
	logic [15:0] width_q [3];

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_limit_q <= RESET_RANGE_LIMIT;
			range_minimum_q <= RESET_RANGE_MINIMUM;
			width_q[0] <= RESET_WIDTH;
			width_q[1] <= RESET_WIDTH;
			width_q[2] <= RESET_WIDTH;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RANGE_LIMIT: range_limit_q <= cfg_data;
				REG_RANGE_MINIMUM: range_minimum_q <= cfg_data;
				REG_WIDTH_X: width_q[0] <= cfg_data;
				REG_WIDTH_Y: width_q[1] <= cfg_data;
				REG_WIDTH_Z: width_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	localparam int DEPTH = CL + 5;
	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	// stage 1: window check and offset vector
	logic ok_s1;
	logic [2:0] mode_s1;
	logic [16:0] dist_s1;
	logic [47:0] start_s1;
	logic signed [16:0] roll_s1, pitch_s1, yaw_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1 <= (in_data.mode <= 3'd5) && (in_data.distance < range_limit_q) &&
				(in_data.distance > range_minimum_q);
			mode_s1 <= in_data.mode;
			dist_s1 <= in_data.mode[0] ? -{1'b0, in_data.distance} : {1'b0, in_data.distance};
			start_s1 <= {in_data.start_x, in_data.start_y, in_data.start_z};
			roll_s1 <= 17'(in_data.roll_angle);
			pitch_s1 <= -17'(in_data.pitch_angle);
			yaw_s1 <= 17'(in_data.yaw_angle);
		end
	end

	logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;
	logic [SIDE-1:0] side_c;
	rtwp_cordic #(.FRAC(F), .STEPS(CORDIC_STEPS), .SIDE(SIDE)) u_roll (
		.clk, .en(adv), .angle(roll_s1),
		.side_in({ok_s1, mode_s1, dist_s1, start_s1}), .side_out(side_c),
		.sin_val(sr), .cos_val(cr));
	rtwp_cordic #(.FRAC(F), .STEPS(CORDIC_STEPS), .SIDE(1)) u_pitch (
		.clk, .en(adv), .angle(pitch_s1), .side_in(1'b0), .side_out(),
		.sin_val(sp), .cos_val(cp));
	rtwp_cordic #(.FRAC(F), .STEPS(CORDIC_STEPS), .SIDE(1)) u_yaw (
		.clk, .en(adv), .angle(yaw_s1), .side_in(1'b0), .side_out(),
		.sin_val(sy), .cos_val(cy));

	logic ok_c;
	logic [2:0] mode_c;
	logic signed [16:0] dist_c;
	logic [47:0] start_c;
	assign {ok_c, mode_c, dist_c, start_c} = side_c;

	logic signed [VW-1:0] v0 [3];
	always_comb begin
		v0[0] = '0; v0[1] = '0; v0[2] = '0;
		case (mode_c[2:1])
			2'd0: v0[0] = VW'(dist_c);
			2'd1: v0[1] = VW'(dist_c);
			2'd2: v0[2] = VW'(dist_c);
			default: ;
		endcase
	end

	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);

	function automatic logic signed [VW-1:0] rnd(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] t;
		t = (s + HALF) >>> F;
		return t[VW-1:0];
	endfunction

	// yaw rotation
	logic signed [VW-1:0] v1 [3];
	logic signed [TW-1:0] sp_a, cp_a, sr_a, cr_a, sr_b, cr_b;
	logic ok_a, ok_b, ok_d;
	logic [47:0] st_a, st_b, st_d;
	always_ff @(posedge clk) begin
		if (adv) begin
			v1[0] <= rnd(SW'(cy * v0[0]) - SW'(sy * v0[1]));
			v1[1] <= rnd(SW'(sy * v0[0]) + SW'(cy * v0[1]));
			v1[2] <= v0[2];
			sp_a <= sp; cp_a <= cp; sr_a <= sr; cr_a <= cr;
			ok_a <= ok_c; st_a <= start_c;
		end
	end

	// pitch rotation
	logic signed [VW-1:0] v2 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			v2[0] <= rnd(SW'(cp_a * v1[0]) + SW'(sp_a * v1[2]));
			v2[1] <= v1[1];
			v2[2] <= rnd(SW'(cp_a * v1[2]) - SW'(sp_a * v1[0]));
			sr_b <= sr_a; cr_b <= cr_a;
			ok_b <= ok_a; st_b <= st_a;
		end
	end

	// roll rotation
	logic signed [VW-1:0] v3 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			v3[0] <= v2[0];
			v3[1] <= rnd(SW'(cr_b * v2[1]) - SW'(sr_b * v2[2]));
			v3[2] <= rnd(SW'(sr_b * v2[1]) + SW'(cr_b * v2[2]));
			ok_d <= ok_b; st_d <= st_b;
		end
	end

	// clamp
	logic [15:0] pt [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [VW:0] c;
			c = VW'(v3[i]) + $signed({5'd0, st_d[47-16*i -: 16]});
			if (c < 0) pt[i] = '0;
			else if (c > $signed({5'd0, width_q[i]})) pt[i] = width_q[i];
			else pt[i] = c[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.valid_res <= ok_d;
			out_data.point_x <= ok_d ? pt[0] : 16'd0;
			out_data.point_y <= ok_d ? pt[1] : 16'd0;
			out_data.point_z <= ok_d ? pt[2] : 16'd0;
		end
	end
	assign out_valid = vld_q[DEPTH-1];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.valid_res |->
		out_data.point_x == 16'd0 && out_data.point_y == 16'd0 && out_data.point_z == 16'd0)
		else $error("rejected beat has nonzero point");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipe moved while stalled");
endmodule
